FILE: hdl/dtq_pkg.sv
// Package for the deadline timer queue.
// Holds operation codes, result status codes and the per-item release limit.
// No dependencies.
package dtq_pkg;

  localparam logic [1:0] OP_RESERVE = 2'd0;
  localparam logic [1:0] OP_PROCESS = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic STATUS_DUE  = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Largest number of jobs one process item may release.
  localparam int MAX_OUT = 32;

  localparam int DELAY_BITS = 32;

endpackage

FILE: hdl/dtq_if.sv
// Valid/ready channel interfaces of the deadline timer queue.
// Depends on dtq_pkg for the delay width.
interface dtq_req_if
  import dtq_pkg::*;
#(
  parameter int HANDLE_BITS = 16,
  parameter int TIME_BITS   = 48
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [TIME_BITS-1:0]   now_time;
  logic [DELAY_BITS-1:0]  delay;
  logic [HANDLE_BITS-1:0] job_handle;

  modport source (output valid, op, now_time, delay, job_handle, input ready);
  modport sink   (input valid, op, now_time, delay, job_handle, output ready);
endinterface

interface dtq_res_if #(
  parameter int HANDLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [HANDLE_BITS-1:0] job_handle_res;
  logic                   status;
  logic                   last;

  modport source (output valid, job_handle_res, status, last, input ready);
  modport sink   (input valid, job_handle_res, status, last, output ready);
endinterface

FILE: hdl/dtq_store.sv
// Entry memory of the deadline timer queue: one write port, one read port
// with registered read data. No package dependencies.
module dtq_store #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/deadline_timer_queue_unit.sv
// Deadline timer queue: pending jobs kept sorted by deadline in a ring buffer.
// Reserve: each pending job with a later deadline is moved one slot by the single
// read/compare/write step, then the new job is written; a full queue rejects the reserve.
// Process: due jobs are released in order until one is not due, every pending job is
// released or the release limit is hit. A stalled result channel holds the item back.
// One item at a time. Synchronous reset empties the queue at once; entries need no clearing.
module deadline_timer_queue_unit
  import dtq_pkg::*;
#(
  parameter int CAPACITY    = 32,
  parameter int HANDLE_BITS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic       clk,
  input  logic       rst,
  dtq_req_if.sink    req,
  dtq_res_if.source  res
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = TIME_BITS + HANDLE_BITS;
  localparam int SUM_W   = ((TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_REJ   = 9'b000000010,
    S_RCALC = 9'b000000100,
    S_RRD   = 9'b000001000,
    S_RCMP  = 9'b000010000,
    S_RWR   = 9'b000100000,
    S_PRD   = 9'b001000000,
    S_PCMP  = 9'b010000000,
    S_PFIN  = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [IDX_W-1:0]       head, head_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [CNT_W-1:0]       pos, pos_next;
  logic [TIME_BITS-1:0]   now_reg;
  logic [DELAY_BITS-1:0]  delay_reg;
  logic [HANDLE_BITS-1:0] handle_reg;
  logic [TIME_BITS-1:0]   due, due_next;
  logic                   held, held_next;
  logic [HANDLE_BITS-1:0] held_handle, held_handle_next;

  logic                   out_free;
  logic                   out_load;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   out_status;
  logic                   out_last;

  logic                   we, re;
  logic [IDX_W-1:0]       waddr, raddr;
  logic [ENTRY_W-1:0]     wdata, rdata;
  logic [TIME_BITS-1:0]   rd_deadline;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [SUM_W-1:0]       due_sum;
  logic                   accept;

  // Logical slot to physical slot; the sum stays below twice the capacity.
  function automatic logic [IDX_W-1:0] phys(input logic [CNT_W-1:0] slot,
                                            input logic [IDX_W-1:0] base);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(slot);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  dtq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_deadline = rdata[ENTRY_W-1:HANDLE_BITS];
  assign rd_handle   = rdata[HANDLE_BITS-1:0];
  assign accept      = req.valid && req.ready;
  assign req.ready   = (state == S_IDLE);
  assign out_free    = !res.valid || res.ready;
  assign due_sum     = SUM_W'(now_reg) + SUM_W'(delay_reg);

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    pos_next         = pos;
    due_next         = due;
    held_next        = held;
    held_handle_next = held_handle;
    out_load         = 1'b0;
    out_handle       = held_handle;
    out_status       = STATUS_DUE;
    out_last         = 1'b0;
    we               = 1'b0;
    re               = 1'b0;
    waddr            = phys(pos, head);
    wdata            = rdata;
    raddr            = phys(pos - CNT_W'(1), head);

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.op)
            OP_RESERVE: begin
              pos_next = count;
              if (count == CNT_W'(CAPACITY)) begin
                state_next = S_REJ;
              end else begin
                state_next = S_RCALC;
              end
            end
            OP_PROCESS: begin
              pos_next   = '0;
              held_next  = 1'b0;
              state_next = S_PRD;
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_REJ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_handle = handle_reg;
          out_status = STATUS_FULL;
          out_last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RCALC: begin
        if (due_sum > SUM_W'(TIME_MAX)) begin
          due_next = TIME_MAX;
        end else begin
          due_next = due_sum[TIME_BITS-1:0];
        end
        state_next = S_RRD;
      end
      S_RRD: begin
        if (pos == '0) begin
          state_next = S_RWR;
        end else begin
          re         = 1'b1;
          state_next = S_RCMP;
        end
      end
      S_RCMP: begin
        // A later deadline moves up one slot; equal ones stay ahead.
        if (rd_deadline > due) begin
          we         = 1'b1;
          pos_next   = pos - CNT_W'(1);
          state_next = S_RRD;
        end else begin
          state_next = S_RWR;
        end
      end
      S_RWR: begin
        we         = 1'b1;
        wdata      = {due, handle_reg};
        count_next = count + CNT_W'(1);
        state_next = S_IDLE;
      end
      S_PRD: begin
        raddr = phys(pos, head);
        if (pos == count || 32'(pos) >= MAX_OUT) begin
          state_next = S_PFIN;
        end else begin
          re         = 1'b1;
          state_next = S_PCMP;
        end
      end
      S_PCMP: begin
        // A due job is held back one step so the last one can be marked.
        if (rd_deadline <= now_reg) begin
          if (!held || out_free) begin
            out_load         = held;
            held_next        = 1'b1;
            held_handle_next = rd_handle;
            pos_next         = pos + CNT_W'(1);
            state_next       = S_PRD;
          end
        end else begin
          state_next = S_PFIN;
        end
      end
      S_PFIN: begin
        if (!held || out_free) begin
          out_load   = held;
          out_last   = 1'b1;
          head_next  = phys(pos, head);
          count_next = count - pos;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      held      <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      held  <= held_next;
      if (out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    due         <= due_next;
    held_handle <= held_handle_next;
    if (accept) begin
      now_reg    <= req.now_time;
      delay_reg  <= req.delay;
      handle_reg <= req.job_handle;
    end
    if (out_load) begin
      res.job_handle_res <= out_handle;
      res.status         <= out_status;
      res.last           <= out_last;
    end
  end

endmodule

FILE: test/deadline_timer_queue_unit_test.sv
// Self-checking testbench for deadline_timer_queue_unit: random and directed reserve,
// process and clear items, with results checked against a sorted-deadline job ledger.
// Depends on dtq_pkg and the dtq_req_if and dtq_res_if interfaces.
module deadline_timer_queue_unit_test;
  import dtq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 32;
  localparam int HANDLE_BITS = 16;
  localparam int TIME_BITS = 48;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [TIME_BITS-1:0] LATEST_TIME = '1;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic                   status;
    logic                   last;
  } release_t;

  // Mirrors the pending jobs in deadline order and keeps the releases still owed.
  class job_ledger;
    logic [TIME_BITS-1:0]   due_at[$];
    logic [HANDLE_BITS-1:0] owner[$];
    release_t               owed[$];
    int                     mismatches = 0;

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    function bit idle();
      return owed.size() == 0;
    endfunction

    function void note_request(logic [1:0] op, logic [TIME_BITS-1:0] now,
                               logic [DELAY_BITS-1:0] delay, logic [HANDLE_BITS-1:0] handle);
      logic [TIME_BITS:0]   sum;
      logic [TIME_BITS-1:0] due;
      int                   pos;
      int                   n;
      case (op)
        OP_RESERVE: begin
          if (due_at.size() >= CAPACITY) begin
            owed.push_back('{handle, STATUS_FULL, 1'b1});
          end else begin
            sum = {1'b0, now} + {{(TIME_BITS - DELAY_BITS + 1){1'b0}}, delay};
            due = sum[TIME_BITS] ? LATEST_TIME : sum[TIME_BITS-1:0];
            // A new job goes behind every job due at the same time or earlier.
            pos = 0;
            while (pos < due_at.size() && due_at[pos] <= due) pos++;
            due_at.insert(pos, due);
            owner.insert(pos, handle);
          end
        end
        OP_PROCESS: begin
          n = 0;
          while (due_at.size() > 0 && n < MAX_OUT && due_at[0] <= now) begin
            owed.push_back('{owner[0], STATUS_DUE, 1'b0});
            void'(due_at.pop_front());
            void'(owner.pop_front());
            n++;
          end
          if (n > 0) owed[owed.size()-1].last = 1'b1;
        end
        OP_CLEAR: begin
          due_at.delete();
          owner.delete();
        end
        default: ;
      endcase
    endfunction

    task check_result(release_t got);
      release_t want;
      if (owed.size() == 0) begin
        report_mismatch("unexpected result, handle", 32'(got.handle), '0);
      end else begin
        want = owed.pop_front();
        if (got.handle !== want.handle) begin
          report_mismatch("job_handle_res", 32'(got.handle), 32'(want.handle));
        end
        if (got.status !== want.status) begin
          report_mismatch("status", 32'(got.status), 32'(want.status));
        end
        if (got.last !== want.last) begin
          report_mismatch("last", 32'(got.last), 32'(want.last));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet = 1'b0;
  int   item_count = 0;

  job_ledger ledger = new();

  dtq_req_if #(.HANDLE_BITS(HANDLE_BITS), .TIME_BITS(TIME_BITS)) req();
  dtq_res_if #(.HANDLE_BITS(HANDLE_BITS)) res();

  deadline_timer_queue_unit #(
    .CAPACITY(CAPACITY),
    .HANDLE_BITS(HANDLE_BITS),
    .TIME_BITS(TIME_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: ready drops in random bursts until the closing stretch.
  initial begin
    int stall_left;
    stall_left = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        res.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      ledger.check_result('{res.job_handle_res, res.status, res.last});
    end
  end

  function automatic logic [TIME_BITS-1:0] random_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_BITS-1:0];
  endfunction

  function automatic logic [HANDLE_BITS-1:0] random_handle();
    return HANDLE_BITS'($urandom);
  endfunction

  function automatic logic [DELAY_BITS-1:0] random_delay();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  // Valid stays high across back-to-back items; it drops only for a random gap or while waiting for releases.
  task automatic send_item(logic [1:0] op, logic [TIME_BITS-1:0] now,
                           logic [DELAY_BITS-1:0] delay, logic [HANDLE_BITS-1:0] handle);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.now_time <= now;
    req.delay <= delay;
    req.job_handle <= handle;
    do @(posedge clk); while (!req.ready);
    ledger.note_request(op, now, delay, handle);
    if (op != OP_UNUSED) item_count++;
  endtask

  task automatic wait_for_releases();
    req.valid <= 1'b0;
    @(posedge clk);
    while (!ledger.idle()) @(posedge clk);
  endtask

  initial begin
    logic [TIME_BITS-1:0] tick;
    int                   pick;
    int                   burst;
    bit                   pressure_done;
    pressure_done = 1'b0;
    req.valid = 1'b0;
    req.op = OP_RESERVE;
    req.now_time = '0;
    req.delay = '0;
    req.job_handle = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, ties, saturated deadlines and the unused code.
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_PROCESS, '0, '0, '0);
    send_item(OP_RESERVE, '0, '0, '0);
    send_item(OP_RESERVE, '0, '0, '1);
    send_item(OP_RESERVE, LATEST_TIME, '1, 16'h1234);
    send_item(OP_RESERVE, 48'hFFFF_FFFF_0000, '1, 16'h5A5A);
    send_item(OP_RESERVE, 48'h0000_0000_0010, 32'd5, 16'h00F0);
    send_item(OP_UNUSED, LATEST_TIME, '1, '1);
    send_item(OP_PROCESS, '0, '1, '1);
    send_item(OP_PROCESS, 48'h0000_0000_0015, '0, '0);
    send_item(OP_PROCESS, LATEST_TIME - TIME_BITS'(1), '0, '0);
    send_item(OP_PROCESS, LATEST_TIME, '0, '0);
    send_item(OP_RESERVE, 48'd100, 32'd10, 16'hA5A5);
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_PROCESS, LATEST_TIME, '0, '0);

    // Fill the store to the brim, then reject once and clear it all.
    tick = random_time();
    repeat (CAPACITY + 1) send_item(OP_RESERVE, tick, $urandom, random_handle());
    send_item(OP_CLEAR, random_time(), $urandom, random_handle());
    send_item(OP_PROCESS, LATEST_TIME, $urandom, random_handle());

    tick = TIME_BITS'($urandom_range(0, 1000));
    while (item_count < 280) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 6);
        repeat (burst) begin
          send_item(OP_RESERVE, tick + TIME_BITS'($urandom_range(0, 3)), random_delay(),
                    random_handle());
        end
        tick = tick + TIME_BITS'($urandom_range(0, 50));
        send_item(OP_PROCESS, tick, $urandom, random_handle());
      end else if (pick == 6) begin
        send_item(OP_CLEAR, random_time(), $urandom, random_handle());
      end else if (pick == 7) begin
        send_item(OP_UNUSED, random_time(), $urandom, random_handle());
      end else if (pick == 8) begin
        tick = random_time();
        send_item(OP_PROCESS, ($urandom_range(0, 3) == 0) ? LATEST_TIME : tick, $urandom,
                  random_handle());
      end else begin
        send_item(OP_PROCESS, tick - TIME_BITS'($urandom_range(0, 20)), $urandom,
                  random_handle());
      end
      if (!pressure_done && item_count >= 140) begin
        wait_for_releases();
        pressure_done = 1'b1;
      end
      quiet = (item_count >= 230);
    end

    quiet = 1'b1;
    wait_for_releases();
    repeat (100) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.idle()) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: deadline_timer_queue_unit.f
hdl/dtq_pkg.sv
hdl/dtq_if.sv
hdl/dtq_store.sv
hdl/deadline_timer_queue_unit.sv
test/deadline_timer_queue_unit_test.sv
